[rtl/core/ibc_pkg.sv]
package ibc_pkg;

  localparam int unsigned MAX_NODES  = 1024;
  localparam int unsigned MAX_EDGES  = 4096;
  localparam int unsigned NODE_DEPTH = MAX_NODES + 1;
  localparam int unsigned ADJ_SLOTS  = 2 * MAX_NODES;

  localparam int unsigned NODE_W  = $clog2(NODE_DEPTH);
  localparam int unsigned DEPTH_W = $clog2(MAX_NODES);
  localparam int unsigned EDGE_AW = $clog2(MAX_EDGES);
  localparam int unsigned ETOT_W  = $clog2(MAX_EDGES + 1);
  localparam int unsigned ADJ_AW  = $clog2(ADJ_SLOTS);
  localparam int unsigned LINK_W  = ADJ_AW + 1;
  localparam int unsigned CNT_W   = 10;

  typedef logic [NODE_W-1:0] node_t;
  typedef logic [LINK_W-1:0] link_t;

  // Top bit set marks the end of a neighbor list.
  localparam link_t NO_LINK = link_t'(1) << ADJ_AW;

  localparam logic [1:0] CMD_LOAD  = 2'd0;
  localparam logic [1:0] CMD_BUILD = 2'd1;
  localparam logic [1:0] CMD_QUERY = 2'd2;

endpackage

[rtl/core/ibc_ram.sv]
module ibc_ram #(
  parameter int unsigned DEPTH = 1024,
  parameter int unsigned WIDTH = 8,
  parameter int unsigned AW    = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

[rtl/core/incremental_bridge_counter_core.sv]
// Channel   Signals                                  Direction
// in        in_valid_i/in_ready_o, cmd, node_a/b     item in
// out       out_valid_o/out_ready_i, bridge_count    item out
// cfg       cfg_we_i, cfg_wdata_i (node_count)       write only
//
// A query merges along tree edges, and each find climbs set-parent links and then
// compresses them. A build runs two node memory sweeps, a pass over the stored edges
// and a walk over the tree edges, plus the finds and merges those edges cause. After
// reset a clearing pass runs before the first item is taken. A finished query waits
// in place while the output register is still occupied.
module incremental_bridge_counter_core
  import ibc_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [1:0]        cmd_i,
  input  logic [NODE_W-1:0] node_a_i,
  input  logic [NODE_W-1:0] node_b_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [CNT_W-1:0]  bridge_count_o,
  input  logic              cfg_we_i,
  input  logic [NODE_W-1:0] cfg_wdata_i
);

  typedef enum logic [4:0] {
    S_SWP, S_IDLE,
    U_NEXT, U_EDGE, U_FB, U_JOIN, U_A1, U_A2,
    B_INIT, B_POP, B_X, B_K, B_ADJ, B_Y, B_CHK,
    P_NEXT, P_EDGE, P_INC,
    F_RD, F_CHK, C_RD, C_WT,
    M_FA, M_FB, M_CMP, M_DA, M_DB, M_TP, M_TPW,
    Q_OUT
  } state_e;

  state_e state_q, fret_q, mret_q, sret_q;

  node_t              ncfg_q, n_use;
  logic [ETOT_W-1:0]  total_q, idx_q;
  logic [LINK_W-1:0]  used_q, k_q;
  node_t              sc_q, fx_q, fc_q, fr_q, ra_q, ea_q, eb_q, ma_q, mb_q;
  node_t              x_q, y_q, head_q, tail_q;
  logic [DEPTH_W-1:0] dx_q, da_q;
  logic [CNT_W-1:0]   bridges_q, bc_q;
  logic               full_q, ov_q;

  // Memory ports.
  logic                     sp_we;  node_t sp_wa, sp_wd, sp_ra, sp_rd;
  logic                     ah_we;  node_t ah_wa, ah_ra; link_t ah_wd, ah_rd;
  logic                     adj_we;
  logic [ADJ_AW-1:0]        adj_wa, adj_ra;
  logic [NODE_W+LINK_W-1:0] adj_wd, adj_rd;
  logic                     tp_we;  node_t tp_wa, tp_wd, tp_ra, tp_rd;
  logic                     td_we;  node_t td_wa, td_ra;
  logic [DEPTH_W-1:0]       td_wd, td_rd;
  logic                     ws_we;  node_t ws_wa, ws_ra; logic ws_wd, ws_rd;
  logic                     wq_we;  node_t wq_wa, wq_wd, wq_ra, wq_rd;
  logic                     ed_we;
  logic [EDGE_AW-1:0]       ed_wa, ed_ra;
  logic [2*NODE_W-1:0]      ed_wd, ed_rd;
  logic                     tf_we;
  logic [EDGE_AW-1:0]       tf_wa, tf_ra;
  logic                     tf_wd, tf_rd;

  logic  in_acc;
  node_t e_a, e_b;

  always_comb begin
    n_use = ncfg_q;
    if (ncfg_q == '0) begin
      n_use = node_t'(1);
    end else if (ncfg_q > node_t'(MAX_NODES)) begin
      n_use = node_t'(MAX_NODES);
    end
  end

  function automatic logic node_ok(input node_t v, input node_t n);
    return (v != '0) && (v <= n);
  endfunction

  assign in_ready_o     = (state_q == S_IDLE);
  assign in_acc         = in_valid_i & in_ready_o;
  assign out_valid_o    = ov_q;
  assign bridge_count_o = bc_q;
  assign e_a            = ed_rd[2*NODE_W-1:NODE_W];
  assign e_b            = ed_rd[NODE_W-1:0];

  // Memory addressing and write data for every state.
  always_comb begin
    sp_we = 1'b0; sp_wa = sc_q; sp_wd = sc_q; sp_ra = fc_q;
    ah_we = 1'b0; ah_wa = sc_q; ah_wd = NO_LINK; ah_ra = ea_q;
    adj_we = 1'b0; adj_wa = used_q[ADJ_AW-1:0]; adj_wd = {eb_q, ah_rd};
    adj_ra = k_q[ADJ_AW-1:0];
    tp_we = 1'b0; tp_wa = sc_q; tp_wd = '0; tp_ra = ma_q;
    td_we = 1'b0; td_wa = sc_q; td_wd = '0; td_ra = ma_q;
    ws_we = 1'b0; ws_wa = sc_q; ws_wd = 1'b0; ws_ra = adj_rd[NODE_W+LINK_W-1:LINK_W];
    wq_we = 1'b0; wq_wa = tail_q; wq_wd = y_q; wq_ra = head_q;
    ed_we = 1'b0; ed_wa = total_q[EDGE_AW-1:0]; ed_wd = {node_a_i, node_b_i};
    ed_ra = idx_q[EDGE_AW-1:0];
    tf_we = 1'b0; tf_wa = idx_q[EDGE_AW-1:0]; tf_wd = 1'b0; tf_ra = idx_q[EDGE_AW-1:0];
    case (state_q)
      S_SWP: begin
        sp_we = 1'b1;
        ah_we = full_q;
        tp_we = full_q;
        td_we = full_q;
        ws_we = full_q;
      end
      S_IDLE: begin
        ed_we = in_acc && (cmd_i == CMD_LOAD) && (total_q < ETOT_W'(MAX_EDGES));
      end
      U_EDGE: tf_we = 1'b1;
      U_A1: begin
        ah_ra  = eb_q;
        adj_we = ~used_q[ADJ_AW];
        ah_we  = ~used_q[ADJ_AW];
        ah_wa  = ea_q;
        ah_wd  = used_q;
      end
      U_A2: begin
        adj_we = ~used_q[ADJ_AW];
        adj_wd = {ea_q, ah_rd};
        ah_we  = ~used_q[ADJ_AW];
        ah_wa  = eb_q;
        ah_wd  = used_q;
        sp_we  = 1'b1;
        sp_wa  = ra_q;
        sp_wd  = fr_q;
        tf_we  = 1'b1;
        tf_wd  = 1'b1;
      end
      B_INIT: begin
        wq_we = 1'b1;
        wq_wa = '0;
        wq_wd = node_t'(1);
        ws_we = 1'b1;
        ws_wa = node_t'(1);
        ws_wd = 1'b1;
      end
      B_X: begin
        ah_ra = wq_rd;
        td_ra = wq_rd;
      end
      B_CHK: begin
        if (!ws_rd && (tail_q <= node_t'(MAX_NODES))) begin
          ws_we = 1'b1; ws_wa = y_q; ws_wd = 1'b1;
          td_we = 1'b1; td_wa = y_q; td_wd = dx_q + DEPTH_W'(1);
          tp_we = 1'b1; tp_wa = y_q; tp_wd = x_q;
          wq_we = 1'b1;
        end
      end
      C_WT: begin
        sp_we = 1'b1;
        sp_wa = fc_q;
        sp_wd = fr_q;
      end
      M_DA: td_ra = mb_q;
      M_TPW: begin
        sp_we = (tp_rd != '0);
        sp_wa = ma_q;
        sp_wd = tp_rd;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_SWP;
      fret_q    <= S_IDLE;
      mret_q    <= S_IDLE;
      sret_q    <= S_IDLE;
      full_q    <= 1'b1;
      sc_q      <= '0;
      ncfg_q    <= node_t'(1);
      total_q   <= '0;
      bridges_q <= '0;
      ov_q      <= 1'b0;
      bc_q      <= '0;
      idx_q     <= '0;
      used_q    <= '0;
      k_q       <= '0;
      fx_q      <= '0;
      fc_q      <= '0;
      fr_q      <= '0;
      ra_q      <= '0;
      ea_q      <= '0;
      eb_q      <= '0;
      ma_q      <= '0;
      mb_q      <= '0;
      x_q       <= '0;
      y_q       <= '0;
      head_q    <= '0;
      tail_q    <= '0;
      dx_q      <= '0;
      da_q      <= '0;
    end else begin
      if (cfg_we_i) begin
        ncfg_q <= cfg_wdata_i;
      end
      if (out_ready_i && (state_q != Q_OUT)) begin
        ov_q <= 1'b0;
      end
      case (state_q)
        S_SWP: begin
          if (sc_q == node_t'(NODE_DEPTH - 1)) begin
            sc_q    <= '0;
            state_q <= sret_q;
          end else begin
            sc_q <= sc_q + node_t'(1);
          end
        end
        S_IDLE: begin
          if (in_acc) begin
            case (cmd_i)
              CMD_LOAD: begin
                if (total_q < ETOT_W'(MAX_EDGES)) begin
                  total_q <= total_q + ETOT_W'(1);
                end
              end
              CMD_BUILD: begin
                idx_q   <= '0;
                used_q  <= '0;
                full_q  <= 1'b1;
                sret_q  <= U_NEXT;
                state_q <= S_SWP;
              end
              CMD_QUERY: begin
                ma_q   <= node_a_i;
                mb_q   <= node_b_i;
                mret_q <= Q_OUT;
                if (node_ok(node_a_i, n_use) && node_ok(node_b_i, n_use)) begin
                  state_q <= M_FA;
                end else begin
                  state_q <= Q_OUT;
                end
              end
              default: ;
            endcase
          end
        end
        // Spanning forest by union-find over the stored edges.
        U_NEXT: begin
          if (idx_q == total_q) begin
            state_q <= B_INIT;
          end else begin
            state_q <= U_EDGE;
          end
        end
        U_EDGE: begin
          ea_q <= e_a;
          eb_q <= e_b;
          if (node_ok(e_a, n_use) && node_ok(e_b, n_use)) begin
            fx_q    <= e_a;
            fc_q    <= e_a;
            fret_q  <= U_FB;
            state_q <= F_RD;
          end else begin
            idx_q   <= idx_q + ETOT_W'(1);
            state_q <= U_NEXT;
          end
        end
        U_FB: begin
          ra_q    <= fr_q;
          fx_q    <= eb_q;
          fc_q    <= eb_q;
          fret_q  <= U_JOIN;
          state_q <= F_RD;
        end
        U_JOIN: begin
          if (ra_q != fr_q) begin
            state_q <= U_A1;
          end else begin
            idx_q   <= idx_q + ETOT_W'(1);
            state_q <= U_NEXT;
          end
        end
        U_A1: begin
          if (!used_q[ADJ_AW]) begin
            used_q <= used_q + link_t'(1);
          end
          state_q <= U_A2;
        end
        U_A2: begin
          if (!used_q[ADJ_AW]) begin
            used_q <= used_q + link_t'(1);
          end
          idx_q   <= idx_q + ETOT_W'(1);
          state_q <= U_NEXT;
        end
        // Breadth-first walk over the tree edges from node 1.
        B_INIT: begin
          head_q  <= '0;
          tail_q  <= node_t'(1);
          state_q <= B_POP;
        end
        B_POP: begin
          if (head_q == tail_q) begin
            bridges_q <= CNT_W'(n_use - node_t'(1));
            full_q    <= 1'b0;
            sret_q    <= P_NEXT;
            idx_q     <= '0;
            state_q   <= S_SWP;
          end else begin
            head_q  <= head_q + node_t'(1);
            state_q <= B_X;
          end
        end
        B_X: begin
          x_q     <= wq_rd;
          state_q <= B_K;
        end
        B_K: begin
          k_q     <= ah_rd;
          dx_q    <= td_rd;
          state_q <= B_ADJ;
        end
        B_ADJ: begin
          if (k_q[ADJ_AW]) begin
            state_q <= B_POP;
          end else begin
            state_q <= B_Y;
          end
        end
        B_Y: begin
          y_q     <= adj_rd[NODE_W+LINK_W-1:LINK_W];
          k_q     <= adj_rd[LINK_W-1:0];
          state_q <= B_CHK;
        end
        B_CHK: begin
          if (!ws_rd && (tail_q <= node_t'(MAX_NODES))) begin
            tail_q <= tail_q + node_t'(1);
          end
          state_q <= B_ADJ;
        end
        // Merge along the cycle of every non-tree edge whose nodes are both in range.
        P_NEXT: begin
          if (idx_q == total_q) begin
            state_q <= S_IDLE;
          end else begin
            state_q <= P_EDGE;
          end
        end
        P_EDGE: begin
          if (tf_rd || !node_ok(e_a, n_use) || !node_ok(e_b, n_use)) begin
            idx_q   <= idx_q + ETOT_W'(1);
            state_q <= P_NEXT;
          end else begin
            ma_q    <= e_a;
            mb_q    <= e_b;
            mret_q  <= P_INC;
            state_q <= M_FA;
          end
        end
        P_INC: begin
          idx_q   <= idx_q + ETOT_W'(1);
          state_q <= P_NEXT;
        end
        // Find the set root of fx_q, then point the whole path at it.
        F_RD: state_q <= F_CHK;
        F_CHK: begin
          if (sp_rd == fc_q) begin
            fr_q    <= fc_q;
            fc_q    <= fx_q;
            state_q <= C_RD;
          end else begin
            fc_q    <= sp_rd;
            state_q <= F_RD;
          end
        end
        C_RD: begin
          if (fc_q == fr_q) begin
            state_q <= fret_q;
          end else begin
            state_q <= C_WT;
          end
        end
        C_WT: begin
          fc_q    <= sp_rd;
          state_q <= C_RD;
        end
        // Climb from the deeper root to its tree parent until roots meet or it has no tree parent.
        M_FA: begin
          fx_q    <= ma_q;
          fc_q    <= ma_q;
          fret_q  <= M_FB;
          state_q <= F_RD;
        end
        M_FB: begin
          ma_q    <= fr_q;
          fx_q    <= mb_q;
          fc_q    <= mb_q;
          fret_q  <= M_CMP;
          state_q <= F_RD;
        end
        M_CMP: begin
          mb_q <= fr_q;
          if (ma_q == fr_q) begin
            state_q <= mret_q;
          end else begin
            state_q <= M_DA;
          end
        end
        M_DA: begin
          da_q    <= td_rd;
          state_q <= M_DB;
        end
        M_DB: begin
          if (da_q < td_rd) begin
            ma_q <= mb_q;
            mb_q <= ma_q;
          end
          state_q <= M_TP;
        end
        M_TP: state_q <= M_TPW;
        M_TPW: begin
          if (tp_rd == '0) begin
            state_q <= mret_q;
          end else begin
            if (bridges_q != '0) begin
              bridges_q <= bridges_q - CNT_W'(1);
            end
            state_q <= M_FA;
          end
        end
        Q_OUT: begin
          if (!ov_q || out_ready_i) begin
            ov_q    <= 1'b1;
            bc_q    <= bridges_q;
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  ibc_ram #(.DEPTH(NODE_DEPTH), .WIDTH(NODE_W)) u_sp (
    .clk_i, .we_i(sp_we), .waddr_i(sp_wa), .wdata_i(sp_wd), .raddr_i(sp_ra), .rdata_o(sp_rd)
  );
  ibc_ram #(.DEPTH(NODE_DEPTH), .WIDTH(LINK_W)) u_ah (
    .clk_i, .we_i(ah_we), .waddr_i(ah_wa), .wdata_i(ah_wd), .raddr_i(ah_ra), .rdata_o(ah_rd)
  );
  ibc_ram #(.DEPTH(ADJ_SLOTS), .WIDTH(NODE_W + LINK_W)) u_adj (
    .clk_i, .we_i(adj_we), .waddr_i(adj_wa), .wdata_i(adj_wd), .raddr_i(adj_ra),
    .rdata_o(adj_rd)
  );
  ibc_ram #(.DEPTH(NODE_DEPTH), .WIDTH(NODE_W)) u_tp (
    .clk_i, .we_i(tp_we), .waddr_i(tp_wa), .wdata_i(tp_wd), .raddr_i(tp_ra), .rdata_o(tp_rd)
  );
  ibc_ram #(.DEPTH(NODE_DEPTH), .WIDTH(DEPTH_W)) u_td (
    .clk_i, .we_i(td_we), .waddr_i(td_wa), .wdata_i(td_wd), .raddr_i(td_ra), .rdata_o(td_rd)
  );
  ibc_ram #(.DEPTH(NODE_DEPTH), .WIDTH(1)) u_ws (
    .clk_i, .we_i(ws_we), .waddr_i(ws_wa), .wdata_i(ws_wd), .raddr_i(ws_ra), .rdata_o(ws_rd)
  );
  ibc_ram #(.DEPTH(NODE_DEPTH), .WIDTH(NODE_W)) u_wq (
    .clk_i, .we_i(wq_we), .waddr_i(wq_wa), .wdata_i(wq_wd), .raddr_i(wq_ra), .rdata_o(wq_rd)
  );
  ibc_ram #(.DEPTH(MAX_EDGES), .WIDTH(2 * NODE_W)) u_ed (
    .clk_i, .we_i(ed_we), .waddr_i(ed_wa), .wdata_i(ed_wd), .raddr_i(ed_ra), .rdata_o(ed_rd)
  );
  ibc_ram #(.DEPTH(MAX_EDGES), .WIDTH(1)) u_tf (
    .clk_i, .we_i(tf_we), .waddr_i(tf_wa), .wdata_i(tf_wd), .raddr_i(tf_ra), .rdata_o(tf_rd)
  );

endmodule

[tb/sv/incremental_bridge_counter_core_test.sv]
module incremental_bridge_counter_core_test;
  timeunit 1ns;
  timeprecision 1ps;
  import ibc_pkg::*;

  localparam logic [1:0] CMD_SPARE = 2'd3;
  localparam int SETTLE_CYCLES = 16;
  localparam int STALL_LIMIT = 2000000;
  localparam int LONG_HOLD = 400;
  localparam int ITEM_GOAL = 1500;

  typedef enum logic [1:0] {STEP_ITEM, STEP_CFG, STEP_DRAIN} step_kind_e;
  typedef struct {
    step_kind_e  kind;
    logic [1:0]  cmd;
    node_t       a;
    node_t       b;
    int          gap;
  } step_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic [1:0] cmd_i = CMD_LOAD;
  node_t node_a_i = '0;
  node_t node_b_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic [CNT_W-1:0] bridge_count_o;
  logic cfg_we_i = 1'b0;
  node_t cfg_wdata_i = '0;

  incremental_bridge_counter_core u_dut (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .cmd_i, .node_a_i, .node_b_i,
    .out_valid_o, .out_ready_i, .bridge_count_o, .cfg_we_i, .cfg_wdata_i
  );

  always #6 clk_i = ~clk_i;

  // Shadow copy of the graph state, updated as items are accepted.
  node_t       node_count_reg = node_t'(1);
  node_t       stored_a[MAX_EDGES];
  node_t       stored_b[MAX_EDGES];
  int          stored_total = 0;
  bit          joined_tree[MAX_EDGES];
  int          nbr_to[ADJ_SLOTS];
  int          nbr_next[ADJ_SLOTS];
  int          nbr_head[NODE_DEPTH];
  int          uf_up[NODE_DEPTH];
  int          tree_up[NODE_DEPTH];
  int          tree_lvl[NODE_DEPTH];
  int          bfs_order[NODE_DEPTH];
  bit          bfs_seen[NODE_DEPTH];
  int          bridges_now = 0;

  logic [CNT_W-1:0] counts_due[$];
  step_t       pending_q[$];
  bit          mismatch_seen = 0;
  int          items_taken = 0;
  int          counts_checked = 0;
  int          builds_taken = 0;
  int          dropped_loads = 0;
  int          settings_used = 0;

  function automatic int nodes_active();
    if (node_count_reg < 1) return 1;
    if (node_count_reg > MAX_NODES) return MAX_NODES;
    return int'(node_count_reg);
  endfunction

  function automatic bit in_graph(int v, int n);
    return v >= 1 && v <= n;
  endfunction

  function automatic int set_top(int x);
    int r;
    int up;
    r = x;
    while (uf_up[r] != r) r = uf_up[r];
    while (x != r) begin
      up = uf_up[x];
      uf_up[x] = r;
      x = up;
    end
    return r;
  endfunction

  function automatic int join_cycle(int a, int b);
    int merged;
    int t;
    bit done;
    merged = 0;
    done = 0;
    while (!done) begin
      a = set_top(a);
      b = set_top(b);
      if (a == b) done = 1;
      else begin
        if (tree_lvl[a] < tree_lvl[b]) begin
          t = a; a = b; b = t;
        end
        if (tree_up[a] == 0) done = 1;
        else begin
          uf_up[a] = tree_up[a];
          merged++;
        end
      end
    end
    return merged;
  endfunction

  function automatic void drop_bridges(int by);
    bridges_now = (by >= bridges_now) ? 0 : bridges_now - by;
  endfunction

  function automatic void link_nbr(int from, int to, ref int used);
    if (used >= ADJ_SLOTS) return;
    nbr_to[used] = to;
    nbr_next[used] = nbr_head[from];
    nbr_head[from] = used;
    used++;
  endfunction

  function automatic void rebuild_tree();
    int n, used, head, tail, x, y, k, ra, rb, a, b;
    n = nodes_active();
    used = 0;
    head = 0;
    tail = 0;
    for (int i = 0; i < NODE_DEPTH; i++) begin
      uf_up[i] = i;
      nbr_head[i] = -1;
      tree_up[i] = 0;
      tree_lvl[i] = 0;
      bfs_seen[i] = 0;
    end
    for (int i = 0; i < stored_total; i++) begin
      a = stored_a[i];
      b = stored_b[i];
      joined_tree[i] = 0;
      if (in_graph(a, n) && in_graph(b, n)) begin
        ra = set_top(a);
        rb = set_top(b);
        if (ra != rb) begin
          link_nbr(a, b, used);
          link_nbr(b, a, used);
          uf_up[ra] = rb;
          joined_tree[i] = 1;
        end
      end
    end
    bfs_order[tail++] = 1;
    bfs_seen[1] = 1;
    while (head < tail) begin
      x = bfs_order[head++];
      k = nbr_head[x];
      while (k >= 0) begin
        y = nbr_to[k];
        if (!bfs_seen[y] && tail <= MAX_NODES) begin
          bfs_seen[y] = 1;
          tree_lvl[y] = tree_lvl[x] + 1;
          tree_up[y] = x;
          bfs_order[tail++] = y;
        end
        k = nbr_next[k];
      end
    end
    bridges_now = n - 1;
    for (int i = 0; i < NODE_DEPTH; i++) uf_up[i] = i;
    for (int i = 0; i < stored_total; i++) begin
      a = stored_a[i];
      b = stored_b[i];
      if (!joined_tree[i] && in_graph(a, n) && in_graph(b, n))
        drop_bridges(join_cycle(a, b));
    end
  endfunction

  function automatic void take_item(logic [1:0] cmd, node_t a, node_t b);
    int n;
    n = nodes_active();
    case (cmd)
      CMD_LOAD: begin
        if (stored_total < MAX_EDGES) begin
          stored_a[stored_total] = a;
          stored_b[stored_total] = b;
          stored_total++;
        end else begin
          dropped_loads++;
        end
      end
      CMD_BUILD: begin
        rebuild_tree();
        builds_taken++;
      end
      CMD_QUERY: begin
        if (in_graph(a, n) && in_graph(b, n)) drop_bridges(join_cycle(a, b));
        counts_due.insert(counts_due.size(), CNT_W'(bridges_now));
      end
      default: ;
    endcase
  endfunction

  initial begin
    for (int i = 0; i < NODE_DEPTH; i++) begin
      uf_up[i] = i;
      nbr_head[i] = -1;
      tree_up[i] = 0;
      tree_lvl[i] = 0;
    end
  end

  // Sender side.
  int wait_left = 0;
  int settle_cnt = 0;

  always @(posedge clk_i or negedge rst_ni) begin : drive_items
    logic valid_nx;
    logic we_nx;
    step_t head_step;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      cfg_we_i <= 1'b0;
      wait_left <= 0;
      settle_cnt <= 0;
    end else begin
      valid_nx = in_valid_i;
      we_nx = 1'b0;
      if (in_valid_i && in_ready_o) begin
        take_item(cmd_i, node_a_i, node_b_i);
        items_taken++;
        valid_nx = 1'b0;
      end
      if (counts_due.size() == 0 && !in_valid_i) settle_cnt <= settle_cnt + 1;
      else settle_cnt <= 0;
      if (!valid_nx && pending_q.size() > 0) begin
        head_step = pending_q[0];
        if (wait_left > 0) begin
          wait_left <= wait_left - 1;
        end else if (head_step.kind == STEP_ITEM) begin
          if (head_step.gap > 0) begin
            wait_left <= head_step.gap - 1;
            pending_q[0].gap = 0;
          end else begin
            void'(pending_q.pop_front());
            cmd_i <= head_step.cmd;
            node_a_i <= head_step.a;
            node_b_i <= head_step.b;
            valid_nx = 1'b1;
          end
        end else if (counts_due.size() == 0 && settle_cnt >= SETTLE_CYCLES &&
                     in_ready_o) begin
          // The block is idle, so no build or query is in flight.
          void'(pending_q.pop_front());
          if (head_step.kind == STEP_CFG) begin
            we_nx = 1'b1;
            cfg_wdata_i <= head_step.a;
            node_count_reg = head_step.a;
            settings_used++;
          end
        end
      end
      in_valid_i <= valid_nx;
      cfg_we_i <= we_nx;
    end
  end

  // Receiver side.
  int stall_left = 0;
  int hold_left = 0;
  bit hold_done = 0;

  always @(posedge clk_i or negedge rst_ni) begin : check_counts
    logic [CNT_W-1:0] want;
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        if (counts_due.size() == 0) begin
          $display("%0t: bridge_count with none due: expected none actual %0d",
                   $realtime, bridge_count_o);
          mismatch_seen = 1;
        end else begin
          want = counts_due.pop_front();
          if (want !== bridge_count_o) begin
            $display("%0t: bridge_count mismatch: expected %0d actual %0d",
                     $realtime, want, bridge_count_o);
            mismatch_seen = 1;
          end
        end
        counts_checked++;
        // Every fourth block of 64 results runs with the receiver always ready.
        stall_left = ((counts_checked / 64) % 4 == 3) ? 0 : $urandom_range(0, 18);
        if (counts_checked == 300 && !hold_done) begin
          hold_left = LONG_HOLD;
          hold_done = 1;
        end
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  int idle_run = 0;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) idle_run <= 0;
      else idle_run <= idle_run + 1;
      if (idle_run >= STALL_LIMIT) begin
        $display("Some tests failed");
        $finish;
      end
    end
  end

  // Stimulus generation.
  int gap_top = 18;
  int items_made = 0;
  int loads_made = 0;

  task automatic add_item(logic [1:0] cmd, int a, int b);
    step_t s;
    s.kind = STEP_ITEM;
    s.cmd = cmd;
    s.a = node_t'(a);
    s.b = node_t'(b);
    s.gap = (gap_top == 0) ? 0 : $urandom_range(0, gap_top);
    pending_q.insert(pending_q.size(), s);
    items_made++;
    if (cmd == CMD_LOAD) loads_made++;
  endtask

  task automatic add_ctrl(step_kind_e kind, int value);
    step_t s;
    s.kind = kind;
    s.cmd = CMD_LOAD;
    s.a = node_t'(value);
    s.b = '0;
    s.gap = 0;
    pending_q.insert(pending_q.size(), s);
  endtask

  function automatic int clamp_nodes(int v);
    return (v < 1) ? 1 : (v > MAX_NODES) ? MAX_NODES : v;
  endfunction

  task automatic add_phase(int setting);
    int n, loads, queries, v, roll;
    n = clamp_nodes(setting);
    add_ctrl(STEP_CFG, setting);
    gap_top = ($urandom_range(0, 4) == 0) ? 0 : 18;
    loads = $urandom_range(2, 30);
    for (int i = 0; i < loads; i++) begin
      roll = $urandom_range(0, 9);
      if (roll == 0) add_item(CMD_LOAD, $urandom_range(0, 2047), $urandom_range(0, 2047));
      else if (roll < 7 && n > 1) begin
        // Tree-shaped edges keep most small graphs connected.
        v = $urandom_range(2, n);
        add_item(CMD_LOAD, v, $urandom_range(1, v - 1));
      end else add_item(CMD_LOAD, $urandom_range(1, n), $urandom_range(1, n));
    end
    add_item(CMD_BUILD, $urandom_range(0, 2047), $urandom_range(0, 2047));
    queries = $urandom_range(5, 30);
    for (int i = 0; i < queries; i++) begin
      roll = $urandom_range(0, 19);
      if (roll == 0) add_item(CMD_SPARE, $urandom_range(0, 2047), $urandom_range(0, 2047));
      else if (roll == 1) add_item(CMD_LOAD, $urandom_range(1, n), $urandom_range(1, n));
      else if (roll == 2) add_item(CMD_QUERY, $urandom_range(0, 2047), $urandom_range(0, 2047));
      else if (roll == 3) add_ctrl(STEP_DRAIN, 0);
      else add_item(CMD_QUERY, $urandom_range(1, n), $urandom_range(1, n));
    end
    // Ending on a query means the block is idle once its count comes back.
    add_item(CMD_QUERY, $urandom_range(1, n), $urandom_range(1, n));
  endtask

  initial begin : run_test
    int extremes[5];
    int setting;
    extremes = '{0, 1, 2, 1024, 2047};

    gap_top = 18;
    add_item(CMD_QUERY, 1, 1);
    add_item(CMD_SPARE, 2047, 0);
    add_ctrl(STEP_CFG, 5);
    add_item(CMD_LOAD, 1, 2);
    add_item(CMD_LOAD, 2, 3);
    add_item(CMD_LOAD, 3, 4);
    add_item(CMD_LOAD, 4, 5);
    add_item(CMD_LOAD, 0, 3);
    add_item(CMD_LOAD, 6, 2);
    add_item(CMD_LOAD, 2047, 1);
    add_item(CMD_LOAD, 1024, 1024);
    add_item(CMD_LOAD, 4, 3);
    add_item(CMD_BUILD, 0, 0);
    add_item(CMD_QUERY, 1, 5);
    add_item(CMD_QUERY, 0, 1);
    add_item(CMD_QUERY, 2047, 2047);
    add_item(CMD_QUERY, 2, 4);
    add_item(CMD_QUERY, 5, 5);
    add_item(CMD_QUERY, 1, 2);
    add_item(CMD_BUILD, 2047, 1024);
    add_item(CMD_QUERY, 1, 3);

    while (items_made < ITEM_GOAL) begin
      if ($urandom_range(0, 3) == 0) setting = extremes[$urandom_range(0, 4)];
      else setting = $urandom_range(2, 40);
      add_phase(setting);
    end

    // A larger batch of loads on the largest graph.
    add_ctrl(STEP_CFG, 1024);
    gap_top = 2;
    for (int i = 0; i < 300; i++)
      add_item(CMD_LOAD, $urandom_range(1, 1024), $urandom_range(1, 1024));
    gap_top = 18;
    add_item(CMD_BUILD, 1, 1);
    for (int i = 0; i < 60; i++)
      add_item(CMD_QUERY, $urandom_range(1, 1024), $urandom_range(1, 1024));

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    do @(posedge clk_i);
    while (pending_q.size() != 0 || in_valid_i || counts_due.size() != 0);
    repeat (40) @(posedge clk_i);
    if (counts_due.size() != 0) begin
      $display("%0t: %0d bridge counts never arrived", $realtime, counts_due.size());
      mismatch_seen = 1;
    end
    $display("Ran %0d items with %0d builds over %0d node settings; checked %0d counts.",
             items_taken, builds_taken, settings_used, counts_checked);
    $display("Sent %0d loads; %0d of them were dropped at a full edge store.",
             loads_made, dropped_loads);
    if (!mismatch_seen) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

[filelist.f]
rtl/core/ibc_pkg.sv
rtl/core/ibc_ram.sv
rtl/core/incremental_bridge_counter_core.sv
tb/sv/incremental_bridge_counter_core_test.sv
